/* hdl/ahto_pkg.sv */
// Package for the arc-hybrid transition oracle unit.
// Holds the size defaults, request and action codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package ahto_pkg;

   localparam int unsigned MAX_WORDS_DEF = 64;
   localparam int unsigned WORD_W_DEF    = $clog2(MAX_WORDS_DEF + 2);

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ACTION = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic [1:0] ACT_SHIFT = 2'd1;
   localparam logic [1:0] ACT_RIGHT = 2'd2;
   localparam logic [1:0] ACT_LEFT  = 2'd3;

   localparam int unsigned MASK_SHIFT = 0;
   localparam int unsigned MASK_RIGHT = 1;
   localparam int unsigned MASK_LEFT  = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ_WAIT,
      ST_READ_DONE,
      ST_ACT_RD0,
      ST_ACT_RD1,
      ST_ACT_RD2,
      ST_SCAN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_load;
      logic read_done;
      logic act_rd0;
      logic act_rd1;
      logic act_rd2;
      logic scan_run;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

/* hdl/ahto_if.sv */
// Request and response channel interfaces of the transition oracle unit.
// Valid/ready handshake plus payload. Depends on ahto_pkg for default widths.
interface ahto_req_if import ahto_pkg::*; #(
   parameter int unsigned WORD_W = WORD_W_DEF
);
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [WORD_W-1:0] word_index;
   logic [WORD_W-1:0] gold_head;
   logic              last_word;
   logic [1:0]        action;

   modport source (output valid, req_type, word_index, gold_head, last_word, action,
                   input ready);
   modport sink   (input valid, req_type, word_index, gold_head, last_word, action,
                   output ready);
endinterface

interface ahto_rsp_if import ahto_pkg::*; #(
   parameter int unsigned WORD_W = WORD_W_DEF
);
   logic              valid;
   logic              ready;
   logic [2:0]        valid_mask;
   logic [2:0]        gold_mask;
   logic              accepted;
   logic              arc_wrong;
   logic [WORD_W-1:0] next_index;
   logic [WORD_W-1:0] stack_count;
   logic              done_res;
   logic [WORD_W-1:0] head_value;

   modport source (output valid, valid_mask, gold_mask, accepted, arc_wrong, next_index,
                          stack_count, done_res, head_value,
                   input ready);
   modport sink   (input valid, valid_mask, gold_mask, accepted, arc_wrong, next_index,
                         stack_count, done_res, head_value,
                   output ready);
endinterface

/* hdl/arc_hybrid_transition_oracle_unit.sv */
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    req_type, word_index, gold_head, last_word, action
// rsp_chan  out  valid/ready    masks, accepted, arc_wrong, next_index, stack_count,
//                               done_res, head_value
// One transaction in flight; req ready only while idle, response held until taken.
// Load: capture, load write, response. Read: capture, wait for the head memory read,
// register the head value, response. Action: capture, stack and gold reads in
// ST_ACT_RD0 to ST_ACT_RD2, the scan, decide, response. The two oracle scans run side
// by side, one stack entry and one buffer word per cycle.
// Synchronous active-high reset; heads clear through per-word valid bits, no clearing pass.
// Top level: controller plus datapath. Depends on ahto_pkg, ahto_if, ahto_ctrl, ahto_dpath.
module arc_hybrid_transition_oracle_unit import ahto_pkg::*; #(
   parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
   input logic        clock,
   input logic        reset,
   ahto_req_if.sink   req_chan,
   ahto_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   ahto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ahto_dpath #(
      .MAX_WORDS (MAX_WORDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_chan.req_type),
      .word_index  (req_chan.word_index),
      .gold_head   (req_chan.gold_head),
      .last_word   (req_chan.last_word),
      .action      (req_chan.action),
      .valid_mask  (rsp_chan.valid_mask),
      .gold_mask   (rsp_chan.gold_mask),
      .accepted    (rsp_chan.accepted),
      .arc_wrong   (rsp_chan.arc_wrong),
      .next_index  (rsp_chan.next_index),
      .stack_count (rsp_chan.stack_count),
      .done_res    (rsp_chan.done_res),
      .head_value  (rsp_chan.head_value)
   );

endmodule

/* hdl/ahto_ctrl.sv */
// Controller of the transition oracle unit: handshakes and sequencing.
// Drives datapath commands per request type. Depends on ahto_pkg.
module ahto_ctrl import ahto_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_LOAD:   state_in = ST_LOAD;
                  REQ_ACTION: state_in = ST_ACT_RD0;
                  REQ_READ:   state_in = ST_READ_WAIT;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.do_load = 1'b1;
            state_in    = ST_RESP;
         end
         ST_READ_WAIT: begin
            state_in = ST_READ_DONE;
         end
         ST_READ_DONE: begin
            cmd.read_done = 1'b1;
            state_in      = ST_RESP;
         end
         ST_ACT_RD0: begin
            cmd.act_rd0 = 1'b1;
            state_in    = ST_ACT_RD1;
         end
         ST_ACT_RD1: begin
            cmd.act_rd1 = 1'b1;
            state_in    = ST_ACT_RD2;
         end
         ST_ACT_RD2: begin
            cmd.act_rd2 = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/ahto_dpath.sv */
// Datapath of the transition oracle unit: stack, gold and head memories,
// parser state, the two oracle scans and the response registers. Depends on ahto_pkg.
module ahto_dpath import ahto_pkg::*; #(
   parameter  int unsigned MAX_WORDS = MAX_WORDS_DEF,
   localparam int unsigned W         = $clog2(MAX_WORDS + 2)
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [1:0]   req_type,
   input  logic [W-1:0] word_index,
   input  logic [W-1:0] gold_head,
   input  logic         last_word,
   input  logic [1:0]   action,
   output logic [2:0]   valid_mask,
   output logic [2:0]   gold_mask,
   output logic         accepted,
   output logic         arc_wrong,
   output logic [W-1:0] next_index,
   output logic [W-1:0] stack_count,
   output logic         done_res,
   output logic [W-1:0] head_value
);

   localparam int unsigned SLOTS = MAX_WORDS + 1;
   localparam int unsigned AW    = $clog2(SLOTS);
   localparam logic [W-1:0] SLOTS_W  = W'(SLOTS);
   localparam logic [W-1:0] MAXW_W   = W'(MAX_WORDS);
   localparam logic [W-1:0] ONE_W    = W'(1);
   localparam logic [W-1:0] TWO_W    = W'(2);
   localparam logic [W:0]   SLOTS_W1 = (W + 1)'(SLOTS);

   logic [W-1:0] stack_mem [SLOTS];
   logic [W-1:0] gold_mem  [SLOTS];
   logic [W-1:0] head_mem  [SLOTS];

   // request registers
   logic [1:0]   req_type_ff;
   logic [W-1:0] widx_ff, ghead_ff;
   logic         last_ff;
   logic [1:0]   action_ff;

   // parser state
   logic [W-1:0]     sp_ff, sp_in;
   logic [W-1:0]     bi_ff, bi_in;
   logic [W-1:0]     len_ff, len_in;
   logic [SLOTS-1:0] head_valid_ff, head_valid_in;

   // memory read data
   logic [W-1:0] stack_rdata_ff, gold_a_rdata_ff, gold_b_rdata_ff, head_rdata_ff;
   logic         gold_a_zero_ff;

   // oracle operands
   logic [W-1:0] top_ff, top_in, below_ff, below_in;
   logic [W-1:0] gidx_ff, gidx_in, gtop_ff, gtop_in;

   // scans
   logic [W-1:0] sp_ptr_ff, sp_ptr_in, s2_ff;
   logic         sv1_ff, sv1_in, sv2_ff, sv2_in;
   logic [W:0]   rs_ptr_ff, rs_ptr_in;
   logic         rv1_ff, rv1_in;
   logic [W-1:0] b1_ff;
   logic         link_stack_ff, link_stack_in, link_rest_ff, link_rest_in;

   // response registers
   logic [2:0]   vmask_ff, vmask_in, gmask_ff, gmask_in;
   logic         acc_ff, acc_in, wrong_ff, wrong_in;
   logic [W-1:0] headv_ff, headv_in;

   logic [W-1:0]  stack_raddr_w, gold_a_addr_w;
   logic [AW-1:0] stack_waddr;
   logic [W-1:0]  stack_wdata;
   logic          stack_we;
   logic [W-1:0]  gold_a_val;
   logic          s_issue, b_issue;
   logic          widx_ok, v_sh, v_rt, v_lf, act_shift, act_arc;
   logic [W-1:0]  arc_head;
   logic [2:0]    gmask_c;

   assign gold_a_val = gold_a_zero_ff ? '0 : gold_a_rdata_ff;
   assign widx_ok    = (widx_ff >= ONE_W) && (widx_ff <= MAXW_W);

   assign s_issue = sp_ptr_ff < sp_ff;
   assign b_issue = (rs_ptr_ff <= {1'b0, len_ff}) && (rs_ptr_ff < SLOTS_W1);
   assign status.scan_done = !s_issue && !sv1_ff && !sv2_ff && !b_issue && !rv1_ff;

   // memory addressing
   always_comb begin
      if (cmd.act_rd0) begin
         stack_raddr_w = sp_ff - ONE_W;
      end else if (cmd.act_rd1) begin
         stack_raddr_w = sp_ff - TWO_W;
      end else begin
         stack_raddr_w = sp_ptr_ff;
      end
      gold_a_addr_w = cmd.act_rd0 ? bi_ff : stack_rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rdata_ff <= stack_mem[stack_raddr_w[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.do_load && widx_ok) begin
         gold_mem[widx_ff[AW-1:0]] <= ghead_ff;
      end
      gold_a_rdata_ff <= gold_mem[gold_a_addr_w[AW-1:0]];
      gold_a_zero_ff  <= (gold_a_addr_w == '0) || (gold_a_addr_w >= SLOTS_W);
      gold_b_rdata_ff <= gold_mem[rs_ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && act_arc) begin
         head_mem[top_ff[AW-1:0]] <= arc_head;
      end
      head_rdata_ff <= head_mem[widx_ff[AW-1:0]];
   end

   // oracle and transition
   always_comb begin
      v_sh = (bi_ff <= len_ff) && (sp_ff < SLOTS_W);
      v_rt = sp_ff >= TWO_W;
      v_lf = (sp_ff != '0) && (bi_ff <= len_ff);
      gmask_c = '0;
      if (v_sh && ((sp_ff == '0) || (gidx_ff == top_ff))) begin
         gmask_c[MASK_SHIFT] = 1'b1;
      end else if (v_lf && (gtop_ff == bi_ff)) begin
         gmask_c[MASK_LEFT] = 1'b1;
      end else begin
         gmask_c[MASK_SHIFT] = v_sh && !link_stack_ff;
         if ((sp_ff != '0) && !link_rest_ff) begin
            gmask_c[MASK_RIGHT] = v_rt;
            gmask_c[MASK_LEFT]  = v_lf && !(v_rt && (gtop_ff == below_ff));
         end
      end
      act_shift = (action_ff == ACT_SHIFT) && v_sh;
      act_arc   = ((action_ff == ACT_RIGHT) && v_rt) || ((action_ff == ACT_LEFT) && v_lf);
      arc_head  = (action_ff == ACT_RIGHT) ? below_ff : bi_ff;
   end

   always_comb begin
      stack_we    = 1'b0;
      stack_waddr = sp_ff[AW-1:0];
      stack_wdata = bi_ff;
      if (cmd.do_load && widx_ok && (widx_ff == ONE_W)) begin
         stack_we    = 1'b1;
         stack_waddr = '0;
         stack_wdata = '0;
      end else if (cmd.decide && act_shift) begin
         stack_we = 1'b1;
      end
   end

   // next state
   always_comb begin
      sp_in         = sp_ff;
      bi_in         = bi_ff;
      len_in        = len_ff;
      head_valid_in = head_valid_ff;
      top_in        = top_ff;
      below_in      = below_ff;
      gidx_in       = gidx_ff;
      gtop_in       = gtop_ff;
      sp_ptr_in     = sp_ptr_ff;
      sv1_in        = sv1_ff;
      sv2_in        = sv2_ff;
      rs_ptr_in     = rs_ptr_ff;
      rv1_in        = rv1_ff;
      link_stack_in = link_stack_ff;
      link_rest_in  = link_rest_ff;
      vmask_in      = vmask_ff;
      gmask_in      = gmask_ff;
      acc_in        = acc_ff;
      wrong_in      = wrong_ff;
      headv_in      = headv_ff;

      if (cmd.capture) begin
         vmask_in = '0;
         gmask_in = '0;
         acc_in   = 1'b0;
         wrong_in = 1'b0;
         headv_in = '0;
      end

      if (cmd.do_load && widx_ok) begin
         if (widx_ff == ONE_W) begin
            head_valid_in = '0;
            sp_in         = ONE_W;
            bi_in         = ONE_W;
            len_in        = '0;
         end
         if (last_ff) begin
            len_in = widx_ff;
         end
      end

      if (cmd.read_done) begin
         if ((widx_ff < SLOTS_W) && head_valid_ff[widx_ff[AW-1:0]]) begin
            headv_in = head_rdata_ff;
         end
      end

      if (cmd.act_rd1) begin
         top_in  = (sp_ff != '0) ? stack_rdata_ff : '0;
         gidx_in = gold_a_val;
      end

      if (cmd.act_rd2) begin
         below_in      = stack_rdata_ff;
         gtop_in       = gold_a_val;
         sp_ptr_in     = '0;
         sv1_in        = 1'b0;
         sv2_in        = 1'b0;
         rs_ptr_in     = {1'b0, bi_ff} + (W + 1)'(1);
         rv1_in        = 1'b0;
         link_stack_in = 1'b0;
         link_rest_in  = 1'b0;
      end

      if (cmd.scan_run) begin
         sp_ptr_in = s_issue ? sp_ptr_ff + ONE_W : sp_ptr_ff;
         sv1_in    = s_issue;
         sv2_in    = sv1_ff;
         if (sv2_ff && ((gold_a_val == bi_ff) || (s2_ff == gidx_ff))) begin
            link_stack_in = 1'b1;
         end
         rs_ptr_in = b_issue ? rs_ptr_ff + (W + 1)'(1) : rs_ptr_ff;
         rv1_in    = b_issue;
         if (rv1_ff && ((gold_b_rdata_ff == top_ff) || (gtop_ff == b1_ff))) begin
            link_rest_in = 1'b1;
         end
      end

      if (cmd.decide) begin
         vmask_in = {v_lf, v_rt, v_sh};
         gmask_in = gmask_c;
         acc_in   = act_shift || act_arc;
         if (act_shift) begin
            sp_in = sp_ff + ONE_W;
            bi_in = bi_ff + ONE_W;
         end else if (act_arc) begin
            sp_in    = sp_ff - ONE_W;
            head_valid_in[top_ff[AW-1:0]] = 1'b1;
            wrong_in = (top_ff != '0) && (gtop_ff != arc_head);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= '0;
         bi_ff         <= ONE_W;
         len_ff        <= '0;
         head_valid_ff <= '0;
         sv1_ff        <= 1'b0;
         sv2_ff        <= 1'b0;
         rv1_ff        <= 1'b0;
         sp_ptr_ff     <= '0;
         rs_ptr_ff     <= '0;
      end else begin
         sp_ff         <= sp_in;
         bi_ff         <= bi_in;
         len_ff        <= len_in;
         head_valid_ff <= head_valid_in;
         sv1_ff        <= sv1_in;
         sv2_ff        <= sv2_in;
         rv1_ff        <= rv1_in;
         sp_ptr_ff     <= sp_ptr_in;
         rs_ptr_ff     <= rs_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         widx_ff     <= word_index;
         ghead_ff    <= gold_head;
         last_ff     <= last_word;
         action_ff   <= action;
      end
      top_ff        <= top_in;
      below_ff      <= below_in;
      gidx_ff       <= gidx_in;
      gtop_ff       <= gtop_in;
      s2_ff         <= stack_rdata_ff;
      b1_ff         <= rs_ptr_ff[W-1:0];
      link_stack_ff <= link_stack_in;
      link_rest_ff  <= link_rest_in;
      vmask_ff      <= vmask_in;
      gmask_ff      <= gmask_in;
      acc_ff        <= acc_in;
      wrong_ff      <= wrong_in;
      headv_ff      <= headv_in;
   end

   // request type steers the controller and here gates the masks to action responses
   assign valid_mask  = (req_type_ff == REQ_ACTION) ? vmask_ff : '0;
   assign gold_mask   = (req_type_ff == REQ_ACTION) ? gmask_ff : '0;
   assign accepted    = acc_ff;
   assign arc_wrong   = wrong_ff;
   assign next_index  = bi_ff;
   assign stack_count = sp_ff;
   assign done_res    = (sp_ff <= ONE_W) && (bi_ff > len_ff);
   assign head_value  = headv_ff;

endmodule

/* hdl/ahto_checker.sv */
// Port-level checker for the transition oracle unit, bound to the top level.
// Depends only on the top level's channel signals.
module ahto_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_valid_mask,
   input logic [2:0] rsp_gold_mask,
   input logic       rsp_accepted,
   input logic       rsp_arc_wrong
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transaction completed");

   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");

   a_gold_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_gold_mask & ~rsp_valid_mask) == 3'b000))
      else $error("gold action outside valid mask");

   a_wrong_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arc_wrong |-> rsp_accepted && (rsp_valid_mask != 3'b000))
      else $error("wrong arc flagged on a refused action");

endmodule

bind arc_hybrid_transition_oracle_unit ahto_checker u_ahto_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_valid_mask (rsp_chan.valid_mask),
   .rsp_gold_mask  (rsp_chan.gold_mask),
   .rsp_accepted   (rsp_chan.accepted),
   .rsp_arc_wrong  (rsp_chan.arc_wrong)
);
